@@ design/jssc_pkg.sv @@
// ----------------------------------------------------------------------------
// jssc_pkg
// Types, codes and literal tables shared by the JSON scalar syntax checker.
// ----------------------------------------------------------------------------
package jssc_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXPECT  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_NOTSING = 2'd3;

    localparam logic [1:0] KIND_NULL   = 2'd0;
    localparam logic [1:0] KIND_FALSE  = 2'd1;
    localparam logic [1:0] KIND_TRUE   = 2'd2;
    localparam logic [1:0] KIND_NUMBER = 2'd3;

    typedef enum logic [3:0] {
        C_END,
        C_SPACE,
        C_ZERO,
        C_DIGIT,
        C_MINUS,
        C_PLUS,
        C_DOT,
        C_EXP,
        C_OTHER
    } t_class;

    typedef struct packed {
        t_class     cls;
        logic [7:0] ch;
    } t_item;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_LITERAL,
        PH_MINUS,
        PH_ZERO,
        PH_INT,
        PH_DOT,
        PH_FRAC,
        PH_EXP,
        PH_ESIGN,
        PH_EDIGITS,
        PH_TRAIL,
        PH_ERROR
    } t_phase;

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] len;
        case (kind)
            KIND_FALSE: len = 3'd5;
            default:    len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] c;
        c = CH_NUL;
        case (kind)
            KIND_FALSE: begin
                case (pos)
                    3'd0:    c = 8'h66;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h73;
                    3'd4:    c = 8'h65;
                    default: c = CH_NUL;
                endcase
            end
            KIND_TRUE: begin
                case (pos)
                    3'd0:    c = 8'h74;
                    3'd1:    c = 8'h72;
                    3'd2:    c = 8'h75;
                    3'd3:    c = 8'h65;
                    default: c = CH_NUL;
                endcase
            end
            default: begin
                case (pos)
                    3'd0:    c = 8'h6E;
                    3'd1:    c = 8'h75;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h6C;
                    default: c = CH_NUL;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

@@ design/json_scalar_syntax_checker.sv @@
// ----------------------------------------------------------------------------
// json_scalar_syntax_checker
// Checks that a zero-terminated byte stream holds one JSON scalar.
// ----------------------------------------------------------------------------
// Text enters one byte per item on the slave stream; a zero byte ends the
// text and yields one result item (status, value type) on the master stream,
// other bytes yield none. A byte is taken every cycle while the internal queue
// of QUEUE_DEPTH entries has room; the grammar state machine retires one queued
// byte per cycle unless a terminator waits for the result register, so while
// results are taken the sustained rate is one byte per clock. A terminator
// leaves the queue only when the single result register is free or being
// taken, so a stalled master side fills the queue, then holds off the input.
// An accepted terminator passes through the queue, then the result register.
module json_scalar_syntax_checker import jssc_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] ch
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [1:0] status, [3:2] value_type, [7:4] zero
);

    t_item      front_item;
    t_item      queue_item;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    logic [1:0] status;
    logic [1:0] value_type;

    jssc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_ch    (i_s_tdata),
        .i_full  (full),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_item  (front_item)
    );

    jssc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    jssc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_item       (queue_item),
        .o_pop        (pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_status     (status),
        .o_value_type (value_type)
    );

    assign o_m_tdata = {4'b0000, value_type, status};

endmodule

@@ design/jssc_front.sv @@
// ----------------------------------------------------------------------------
// jssc_front
// Input side: accept text bytes and tag each with its character class.
// ----------------------------------------------------------------------------
module jssc_front import jssc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_ch,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_item      o_item
);

    t_class cls;

    always_comb begin
        if (i_ch == CH_NUL) begin
            cls = C_END;
        end else if (i_ch == CH_SPACE || i_ch == CH_TAB || i_ch == CH_LF || i_ch == CH_CR) begin
            cls = C_SPACE;
        end else if (i_ch == CH_ZERO) begin
            cls = C_ZERO;
        end else if (i_ch > CH_ZERO && i_ch <= CH_NINE) begin
            cls = C_DIGIT;
        end else if (i_ch == CH_MINUS) begin
            cls = C_MINUS;
        end else if (i_ch == CH_PLUS) begin
            cls = C_PLUS;
        end else if (i_ch == CH_DOT) begin
            cls = C_DOT;
        end else if (i_ch == CH_LO_E || i_ch == CH_UP_E) begin
            cls = C_EXP;
        end else begin
            cls = C_OTHER;
        end
    end

    assign o_ready    = !i_full;
    assign o_push     = i_valid && !i_full;
    assign o_item.cls = cls;
    assign o_item.ch  = i_ch;

    property p_push_needs_room;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_ready && i_valid);
    endproperty
    a_push_needs_room: assert property (p_push_needs_room)
        else $error("push without room");

    property p_end_only_on_nul;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.cls == C_END) |-> (o_item.ch == CH_NUL);
    endproperty
    a_end_only_on_nul: assert property (p_end_only_on_nul)
        else $error("terminator class on non-zero byte");

    property p_nul_is_end;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.ch == CH_NUL) |-> (o_item.cls == C_END);
    endproperty
    a_nul_is_end: assert property (p_nul_is_end)
        else $error("zero byte not classed as terminator");

endmodule

@@ design/jssc_queue.sv @@
// ----------------------------------------------------------------------------
// jssc_queue
// Short FIFO of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module jssc_queue import jssc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT;
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("queue count beyond depth");

    property p_count_track;
        @(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1);
    endproperty
    a_count_track: assert property (p_count_track)
        else $error("queue count did not advance on push");

    property p_empty_ptrs;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> (r_wr_ptr == r_rd_ptr);
    endproperty
    a_empty_ptrs: assert property (p_empty_ptrs)
        else $error("empty queue with unequal pointers");

endmodule

@@ design/jssc_back.sv @@
// ----------------------------------------------------------------------------
// jssc_back
// Grammar state machine and result register of the scalar syntax checker.
// ----------------------------------------------------------------------------
module jssc_back import jssc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [1:0] o_value_type
);

    t_phase     r_phase, n_phase;
    logic [2:0] r_pos, n_pos;
    logic [1:0] r_status, n_status;
    logic [1:0] r_kind, n_kind;
    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [1:0] r_out_type;
    logic [1:0] res_status;
    logic       is_end;
    logic       lit_ok;
    logic [2:0] len;

    assign is_end = (i_item.cls == C_END);
    assign o_pop  = !i_empty && (!is_end || !r_out_valid || i_ready);
    assign len    = lit_len(r_kind);
    assign lit_ok = (r_pos < len) && (i_item.ch == lit_char(r_kind, r_pos));

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_status   = r_status;
        n_kind     = r_kind;
        res_status = ST_OK;
        case (r_phase)
            PH_LEAD:                                      res_status = ST_EXPECT;
            PH_ZERO, PH_INT, PH_FRAC, PH_EDIGITS, PH_TRAIL: res_status = ST_OK;
            PH_LITERAL, PH_MINUS, PH_DOT, PH_EXP, PH_ESIGN: res_status = ST_INVALID;
            default:                                      res_status = r_status;
        endcase
        if (o_pop) begin
            if (is_end) begin
                n_phase  = PH_LEAD;
                n_pos    = '0;
                n_status = ST_OK;
                n_kind   = KIND_NULL;
            end else begin
                case (r_phase)
                    PH_LEAD: begin
                        if (i_item.cls != C_SPACE) begin
                            n_pos = 3'd1;
                            if (i_item.ch == lit_char(KIND_NULL, 3'd0)) begin
                                n_kind  = KIND_NULL;
                                n_phase = PH_LITERAL;
                            end else if (i_item.ch == lit_char(KIND_FALSE, 3'd0)) begin
                                n_kind  = KIND_FALSE;
                                n_phase = PH_LITERAL;
                            end else if (i_item.ch == lit_char(KIND_TRUE, 3'd0)) begin
                                n_kind  = KIND_TRUE;
                                n_phase = PH_LITERAL;
                            end else begin
                                n_pos  = '0;
                                n_kind = KIND_NUMBER;
                                case (i_item.cls)
                                    C_MINUS: n_phase = PH_MINUS;
                                    C_ZERO:  n_phase = PH_ZERO;
                                    C_DIGIT: n_phase = PH_INT;
                                    default: begin
                                        n_phase  = PH_ERROR;
                                        n_status = ST_INVALID;
                                    end
                                endcase
                            end
                        end
                    end
                    PH_LITERAL: begin
                        if (!lit_ok) begin
                            n_phase  = PH_ERROR;
                            n_status = ST_INVALID;
                        end else begin
                            n_pos = r_pos + 1'b1;
                            if (r_pos + 1'b1 == len) begin
                                n_phase = PH_TRAIL;
                            end
                        end
                    end
                    PH_MINUS, PH_DOT, PH_ESIGN: begin
                        if (i_item.cls == C_ZERO || i_item.cls == C_DIGIT) begin
                            case (r_phase)
                                PH_MINUS: n_phase = (i_item.cls == C_ZERO) ? PH_ZERO : PH_INT;
                                PH_DOT:   n_phase = PH_FRAC;
                                default:  n_phase = PH_EDIGITS;
                            endcase
                        end else begin
                            n_phase  = PH_ERROR;
                            n_status = ST_INVALID;
                        end
                    end
                    PH_EXP: begin
                        case (i_item.cls)
                            C_PLUS, C_MINUS: n_phase = PH_ESIGN;
                            C_ZERO, C_DIGIT: n_phase = PH_EDIGITS;
                            default: begin
                                n_phase  = PH_ERROR;
                                n_status = ST_INVALID;
                            end
                        endcase
                    end
                    PH_ZERO, PH_INT, PH_FRAC, PH_EDIGITS: begin
                        if ((i_item.cls == C_ZERO || i_item.cls == C_DIGIT)
                            && r_phase != PH_ZERO) begin
                            n_phase = r_phase;
                        end else if (i_item.cls == C_DOT
                            && (r_phase == PH_ZERO || r_phase == PH_INT)) begin
                            n_phase = PH_DOT;
                        end else if (i_item.cls == C_EXP && r_phase != PH_EDIGITS) begin
                            n_phase = PH_EXP;
                        end else if (i_item.cls == C_SPACE) begin
                            n_phase = PH_TRAIL;
                        end else begin
                            n_phase  = PH_ERROR;
                            n_status = ST_NOTSING;
                        end
                    end
                    PH_TRAIL: begin
                        if (i_item.cls != C_SPACE) begin
                            n_phase  = PH_ERROR;
                            n_status = ST_NOTSING;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_pos       <= '0;
            r_status    <= ST_OK;
            r_kind      <= KIND_NULL;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_status <= n_status;
            r_kind   <= n_kind;
            if (o_pop && is_end) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_end) begin
            r_out_status <= res_status;
            r_out_type   <= (res_status == ST_OK) ? r_kind : KIND_NULL;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_value_type = r_out_type;

    property p_end_resets;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_end) |=> (r_phase == PH_LEAD && r_status == ST_OK && r_out_valid);
    endproperty
    a_end_resets: assert property (p_end_resets)
        else $error("terminator did not restart the parse");

    property p_error_null;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_type == KIND_NULL);
    endproperty
    a_error_null: assert property (p_error_null)
        else $error("error result with non-null type");

    property p_status_in_error;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_ERROR) |-> (r_status == ST_OK);
    endproperty
    a_status_in_error: assert property (p_status_in_error)
        else $error("kept error code outside error phase");

    property p_no_overwrite;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !(o_pop && is_end);
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("result overwritten before it was taken");

endmodule
